### sv/ptrr_pkg.sv
// Shared types and constants of the process table with round-robin selection.
package ptrr_pkg;

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_EXIT   = 3'd1;
    localparam logic [2:0] OP_FORK   = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [7:0]  DEFAULT_PRIO = 8'd10;
    localparam logic [15:0] IDLE_ID      = 16'd1;
    localparam logic [7:0]  IDLE_PRIO    = 8'd1;
    localparam logic [15:0] FIRST_ID     = 16'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] target_id;
        logic [7:0]  prio_in;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] new_id;
        logic [15:0] parent_out;
        logic [7:0]  prio_out;
        logic [31:0] ticks_out;
        logic [3:0]  cur_slot;
        logic [15:0] cur_id;
    } t_rsp;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] parent;
        logic [7:0]  prio;
        logic [31:0] ticks;
    } t_slot;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic live_set;
        logic live_clr;
    } t_tbl_ctl;

endpackage

### sv/ptrr_req_if.sv
// Request channel: command, target id and priority.
interface ptrr_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] target_id;
    logic [7:0]  prio_in;

    modport source (output valid, output op, output target_id, output prio_in, input ready);
    modport sink   (input valid, input op, input target_id, input prio_in, output ready);
endinterface

### sv/ptrr_rsp_if.sv
// Response channel: status, new id, queried task fields and current task.
interface ptrr_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] new_id;
    logic [15:0] parent_out;
    logic [7:0]  prio_out;
    logic [31:0] ticks_out;
    logic [3:0]  cur_slot;
    logic [15:0] cur_id;

    modport source (output valid, output status, output new_id, output parent_out,
                    output prio_out, output ticks_out, output cur_slot, output cur_id,
                    input ready);
    modport sink   (input valid, input status, input new_id, input parent_out,
                    input prio_out, input ticks_out, input cur_slot, input cur_id,
                    output ready);
endinterface

### sv/ptrr_table.sv
// Slot memory with live and written flags and a registered read port.
module ptrr_table #(
    parameter int SLOTS = 16,
    localparam int SW = $clog2(SLOTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptrr_pkg::t_tbl_ctl i_ctl,
    input  logic [SW-1:0]      i_rd_addr,
    input  logic [SW-1:0]      i_wr_addr,
    input  ptrr_pkg::t_slot    i_wr_data,
    output ptrr_pkg::t_slot    o_rd_data,
    output logic               o_rd_live
);

    ptrr_pkg::t_slot r_mem [SLOTS];
    logic [SLOTS-1:0] r_live;
    logic [SLOTS-1:0] r_wr;

    ptrr_pkg::t_slot r_q;
    logic            r_q_live;
    logic            r_q_wr;
    logic            r_q_zero;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_q      <= r_mem[i_rd_addr];
            r_q_live <= r_live[i_rd_addr];
            r_q_wr   <= r_wr[i_rd_addr];
            r_q_zero <= (i_rd_addr == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= SLOTS'(1);
            r_wr      <= '0;
        end else begin
            if (i_ctl.wr_en) begin
                r_wr[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.live_set) begin
                r_live[i_wr_addr] <= 1'b1;
            end else if (i_ctl.live_clr) begin
                r_live[i_wr_addr] <= 1'b0;
            end
        end
    end

    // Never-written entries read as the reset contents; a free slot has id 0.
    always_comb begin
        if (r_q_wr) begin
            o_rd_data = r_q;
        end else begin
            o_rd_data        = '0;
            o_rd_data.id     = r_q_zero ? ptrr_pkg::IDLE_ID : 16'd0;
            o_rd_data.prio   = r_q_zero ? ptrr_pkg::IDLE_PRIO : 8'd0;
        end
        if (!r_q_live) begin
            o_rd_data.id = 16'd0;
        end
    end

    assign o_rd_live = r_q_live;

endmodule

### sv/ptrr_ctrl.sv
// Sequencer: slot scan with one shared id compare, then the table update.
module ptrr_ctrl #(
    parameter int SLOTS = 16,
    localparam int SW = $clog2(SLOTS),
    localparam int KW = $clog2(SLOTS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ptrr_pkg::t_req     i_req,
    output logic               o_idle,
    input  logic               i_rsp_free,
    output logic               o_rsp_load,
    output ptrr_pkg::t_rsp     o_rsp,
    output ptrr_pkg::t_tbl_ctl o_tbl,
    output logic [SW-1:0]      o_rd_addr,
    output logic [SW-1:0]      o_wr_addr,
    output ptrr_pkg::t_slot    o_wr_data,
    input  ptrr_pkg::t_slot    i_rd_data,
    input  logic               i_rd_live
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EXEC, S_TICK_RD, S_TICK_WR, S_FIN_RD, S_FIN
    } t_state;

    t_state        r_state;
    logic [2:0]    r_op;
    logic [15:0]   r_tid;
    logic [7:0]    r_prio;
    logic [SW-1:0] r_cur;
    logic [15:0]   r_idcnt;
    logic [KW-1:0] r_total;
    logic [SW-1:0] r_addr;
    logic [KW-1:0] r_k;
    logic          r_pend;
    logic [SW-1:0] r_ridx;
    logic          r_found;
    logic [SW-1:0] r_fidx;
    logic          r_free_ok;
    logic [SW-1:0] r_free;
    logic [15:0]   r_cid;
    logic [15:0]   r_mpar;
    logic [7:0]    r_mpr;
    logic [31:0]   r_mtk;
    logic [1:0]    r_status;
    logic [15:0]   r_nid;
    logic [15:0]   r_par;
    logic [7:0]    r_pr;
    logic [31:0]   r_tk;

    logic          w_match;
    logic          w_full;
    logic          w_make;
    logic          w_kill;
    logic          w_scan_end;
    logic [SW-1:0] w_addr_nx;
    logic [SW-1:0] w_cur_nx;
    logic [7:0]    w_pri;
    logic [15:0]   w_id_nx;

    assign w_scan_end = (r_k == KW'(SLOTS));
    assign w_addr_nx  = (r_addr == SW'(SLOTS - 1)) ? '0 : r_addr + SW'(1);
    assign w_cur_nx   = (r_cur == SW'(SLOTS - 1)) ? '0 : r_cur + SW'(1);
    assign w_id_nx    = (r_idcnt == 16'hFFFF) ? 16'd1 : r_idcnt + 16'd1;

    // Tick looks for the next live slot; the other searches for a live id.
    assign w_match = (r_op == ptrr_pkg::OP_TICK) ? i_rd_live
                   : (i_rd_live && (i_rd_data.id == r_tid));

    assign w_full = (r_total >= KW'(SLOTS)) || !r_free_ok;
    assign w_make = (r_state == S_EXEC) && !w_full &&
                    ((r_op == ptrr_pkg::OP_CREATE) ||
                     ((r_op == ptrr_pkg::OP_FORK) && r_found));
    assign w_kill = (r_state == S_EXEC) && (r_op == ptrr_pkg::OP_EXIT) && r_found;
    assign w_pri  = (r_op == ptrr_pkg::OP_CREATE) ? r_prio : r_mpr;

    always_comb begin
        o_tbl     = '0;
        o_rd_addr = r_addr;
        o_wr_addr = r_cur;
        o_wr_data = i_rd_data;
        case (r_state)
            S_SCAN: begin
                o_tbl.rd_en = !w_scan_end;
            end
            S_TICK_RD, S_FIN_RD: begin
                o_tbl.rd_en = 1'b1;
                o_rd_addr   = r_cur;
            end
            S_TICK_WR: begin
                o_tbl.wr_en = 1'b1;
                if (i_rd_data.ticks != 32'hFFFF_FFFF) begin
                    o_wr_data.ticks = i_rd_data.ticks + 32'd1;
                end
            end
            S_EXEC: begin
                if (w_make) begin
                    o_tbl.wr_en      = 1'b1;
                    o_tbl.live_set   = 1'b1;
                    o_wr_addr        = r_free;
                    o_wr_data.id     = r_idcnt;
                    o_wr_data.parent = (r_op == ptrr_pkg::OP_CREATE) ? r_cid : r_tid;
                    o_wr_data.prio   = (w_pri == 8'd0) ? ptrr_pkg::DEFAULT_PRIO : w_pri;
                    o_wr_data.ticks  = 32'd0;
                end else if (w_kill) begin
                    o_tbl.live_clr = 1'b1;
                    o_wr_addr      = r_fidx;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_idcnt <= ptrr_pkg::FIRST_ID;
            r_total <= KW'(1);
            r_pend  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op      <= i_req.op;
                        r_tid     <= i_req.target_id;
                        r_prio    <= i_req.prio_in;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_status  <= ptrr_pkg::ST_OK;
                        r_nid     <= '0;
                        r_par     <= '0;
                        r_pr      <= '0;
                        r_tk      <= '0;
                        r_cid     <= '0;
                        r_addr    <= '0;
                        r_k       <= '0;
                        if (i_req.op == ptrr_pkg::OP_TICK) begin
                            r_state <= (r_total == '0) ? S_FIN_RD : S_TICK_RD;
                        end else if (i_req.op == ptrr_pkg::OP_CREATE ||
                                     i_req.op == ptrr_pkg::OP_EXIT ||
                                     i_req.op == ptrr_pkg::OP_FORK ||
                                     i_req.op == ptrr_pkg::OP_QUERY) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FIN_RD;
                        end
                    end
                end
                S_SCAN: begin
                    r_pend <= !w_scan_end;
                    if (!w_scan_end) begin
                        r_addr <= w_addr_nx;
                        r_k    <= r_k + KW'(1);
                        r_ridx <= r_addr;
                    end
                    if (r_pend) begin
                        if (w_match && !r_found) begin
                            r_found <= 1'b1;
                            r_fidx  <= r_ridx;
                            r_mpar  <= i_rd_data.parent;
                            r_mpr   <= i_rd_data.prio;
                            r_mtk   <= i_rd_data.ticks;
                        end
                        if (!i_rd_live && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= r_ridx;
                        end
                        if (r_ridx == r_cur) begin
                            r_cid <= i_rd_data.id;
                        end
                    end
                    if (w_scan_end && !r_pend) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_op)
                        ptrr_pkg::OP_CREATE, ptrr_pkg::OP_FORK: begin
                            if ((r_op == ptrr_pkg::OP_FORK) && !r_found) begin
                                r_status <= ptrr_pkg::ST_NOT_FOUND;
                            end else if (w_full) begin
                                r_status <= ptrr_pkg::ST_FULL;
                            end else begin
                                r_nid   <= r_idcnt;
                                r_idcnt <= w_id_nx;
                                r_total <= r_total + KW'(1);
                            end
                        end
                        ptrr_pkg::OP_EXIT: begin
                            if (!r_found) begin
                                r_status <= ptrr_pkg::ST_NOT_FOUND;
                            end else begin
                                r_total <= r_total - KW'(1);
                            end
                        end
                        ptrr_pkg::OP_QUERY: begin
                            if (!r_found) begin
                                r_status <= ptrr_pkg::ST_NOT_FOUND;
                            end else begin
                                r_par <= r_mpar;
                                r_pr  <= r_mpr;
                                r_tk  <= r_mtk;
                            end
                        end
                        ptrr_pkg::OP_TICK: begin
                            r_cur <= r_fidx;
                        end
                        default: begin
                        end
                    endcase
                    r_state <= S_FIN_RD;
                end
                S_TICK_RD: begin
                    r_state <= S_TICK_WR;
                end
                S_TICK_WR: begin
                    // Cyclic search starts one past the charged slot.
                    r_addr  <= w_cur_nx;
                    r_k     <= '0;
                    r_state <= S_SCAN;
                end
                S_FIN_RD: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_rsp_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle     = (r_state == S_IDLE);
    assign o_rsp_load = (r_state == S_FIN) && i_rsp_free;

    always_comb begin
        o_rsp.status     = r_status;
        o_rsp.new_id     = r_nid;
        o_rsp.parent_out = r_par;
        o_rsp.prio_out   = r_pr;
        o_rsp.ticks_out  = r_tk;
        o_rsp.cur_slot   = 4'(r_cur);
        o_rsp.cur_id     = i_rd_data.id;
    end

endmodule

### sv/process_table_round_robin.sv
// Process table top level: one request in, one response out, round-robin current task.
// Create, exit, fork and query scan every slot, one slot per cycle through the single read
// port of the slot memory; a tick charges the current task, then scans for the next live
// one; an undefined op or a tick with an empty table skips the scan. One request at a time;
// the next is accepted in the cycle after the response register loads.
// Reset: slot 0 holds the idle task and is the only live slot, written flags clear at once, no clearing pass.
module process_table_round_robin #(
    parameter int SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ptrr_req_if.sink          i_req,
    ptrr_rsp_if.source        o_rsp
);

    localparam int SW = $clog2(SLOTS);

    ptrr_pkg::t_req     w_req;
    ptrr_pkg::t_rsp     w_rsp;
    ptrr_pkg::t_tbl_ctl w_tbl;
    ptrr_pkg::t_slot    w_wr_data;
    ptrr_pkg::t_slot    w_rd_data;
    logic [SW-1:0]      w_rd_addr;
    logic [SW-1:0]      w_wr_addr;
    logic               w_rd_live;
    logic               w_idle;
    logic               w_rsp_load;
    logic               w_rsp_free;

    logic               r_out_vld;
    ptrr_pkg::t_rsp     r_out;

    assign w_req.op        = i_req.op;
    assign w_req.target_id = i_req.target_id;
    assign w_req.prio_in   = i_req.prio_in;
    assign i_req.ready     = w_idle;

    // Response register lets the next request start while this one waits.
    assign w_rsp_free = !r_out_vld || o_rsp.ready;

    ptrr_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_req.valid && w_idle),
        .i_req      (w_req),
        .o_idle     (w_idle),
        .i_rsp_free (w_rsp_free),
        .o_rsp_load (w_rsp_load),
        .o_rsp      (w_rsp),
        .o_tbl      (w_tbl),
        .o_rd_addr  (w_rd_addr),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .i_rd_data  (w_rd_data),
        .i_rd_live  (w_rd_live)
    );

    ptrr_table #(.SLOTS(SLOTS)) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_tbl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data),
        .o_rd_live (w_rd_live)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (w_rsp_load) begin
                r_out_vld <= 1'b1;
                r_out     <= w_rsp;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.new_id     = r_out.new_id;
    assign o_rsp.parent_out = r_out.parent_out;
    assign o_rsp.prio_out   = r_out.prio_out;
    assign o_rsp.ticks_out  = r_out.ticks_out;
    assign o_rsp.cur_slot   = r_out.cur_slot;
    assign o_rsp.cur_id     = r_out.cur_id;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the process table with round-robin selection.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptrr_pkg::*;

    localparam int          N_SLOTS      = 16;
    localparam int          RANDOM_ITEMS = 1000;
    localparam int          STALL_LIMIT  = 500;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [2:0]  OP_UNDEF_LO  = 3'd5;
    localparam logic [2:0]  OP_UNDEF_HI  = 3'd7;
    localparam logic [31:0] TICKS_MAX    = 32'hFFFF_FFFF;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_SPIN} t_mode;

    typedef struct {
        t_req cmd;
        bit   typed;
        t_rsp want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    ptrr_req_if req_ch();
    ptrr_rsp_if rsp_ch();

    process_table_round_robin #(.SLOTS(N_SLOTS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // shadow copy of the task table
    logic        tbl_live   [N_SLOTS];
    logic [15:0] tbl_id     [N_SLOTS];
    logic [15:0] tbl_parent [N_SLOTS];
    logic [7:0]  tbl_prio   [N_SLOTS];
    logic [31:0] tbl_ticks  [N_SLOTS];
    logic [15:0] next_id;
    logic [3:0]  run_slot;
    int          live_count;

    t_rsp     pending_rsp[$];
    t_dir_row dir_rows[$];
    bit       idle_on = 1'b1;
    int       errors;
    int       stall_cycles;
    int       op_seen[8];
    int       n_full, n_not_found, n_empty_table, peak_live;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void table_reset();
        for (int i = 0; i < N_SLOTS; i++) begin
            tbl_live[i]   = 1'b0;
            tbl_id[i]     = '0;
            tbl_parent[i] = '0;
            tbl_prio[i]   = '0;
            tbl_ticks[i]  = '0;
        end
        tbl_live[0] = 1'b1;
        tbl_id[0]   = IDLE_ID;
        tbl_prio[0] = IDLE_PRIO;
        next_id     = FIRST_ID;
        run_slot    = '0;
        live_count  = 1;
    endfunction

    // lowest live slot holding id, N_SLOTS if none
    function automatic int lowest_live(logic [15:0] id);
        for (int i = 0; i < N_SLOTS; i++)
            if (tbl_live[i] && tbl_id[i] == id)
                return i;
        return N_SLOTS;
    endfunction

    function automatic logic [1:0] spawn_task(logic [15:0] parent, logic [7:0] prio,
                                              output logic [15:0] nid);
        int slot;
        nid  = '0;
        slot = N_SLOTS;
        if (live_count >= N_SLOTS)
            return ST_FULL;
        for (int i = N_SLOTS - 1; i >= 0; i--)
            if (!tbl_live[i])
                slot = i;
        if (slot == N_SLOTS)
            return ST_FULL;
        tbl_live[slot]   = 1'b1;
        tbl_id[slot]     = next_id;
        tbl_parent[slot] = parent;
        tbl_prio[slot]   = (prio == 8'd0) ? DEFAULT_PRIO : prio;
        tbl_ticks[slot]  = '0;
        nid              = next_id;
        next_id          = (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
        live_count++;
        return ST_OK;
    endfunction

    function automatic t_rsp apply_command(t_req r);
        t_rsp        o;
        int          slot;
        logic [15:0] nid;
        o = '0;
        case (r.op)
            OP_CREATE: begin
                o.status = spawn_task(tbl_id[run_slot], r.prio_in, nid);
                o.new_id = nid;
            end
            OP_EXIT: begin
                slot = lowest_live(r.target_id);
                if (slot == N_SLOTS) begin
                    o.status = ST_NOT_FOUND;
                end else begin
                    tbl_live[slot] = 1'b0;
                    tbl_id[slot]   = '0;
                    live_count--;
                end
            end
            OP_FORK: begin
                slot = lowest_live(r.target_id);
                if (slot == N_SLOTS) begin
                    o.status = ST_NOT_FOUND;
                end else begin
                    o.status = spawn_task(r.target_id, tbl_prio[slot], nid);
                    o.new_id = nid;
                end
            end
            OP_TICK: begin
                if (live_count != 0) begin
                    // charged even if the current slot was freed
                    if (tbl_ticks[run_slot] != TICKS_MAX)
                        tbl_ticks[run_slot] = tbl_ticks[run_slot] + 32'd1;
                    for (int i = 0; i < N_SLOTS; i++) begin
                        run_slot = run_slot + 4'd1;
                        if (tbl_live[run_slot])
                            break;
                    end
                end
            end
            OP_QUERY: begin
                slot = lowest_live(r.target_id);
                if (slot == N_SLOTS) begin
                    o.status = ST_NOT_FOUND;
                end else begin
                    o.parent_out = tbl_parent[slot];
                    o.prio_out   = tbl_prio[slot];
                    o.ticks_out  = tbl_ticks[slot];
                end
            end
            default: ;
        endcase
        o.cur_slot = run_slot;
        o.cur_id   = tbl_id[run_slot];
        return o;
    endfunction

    function automatic t_rsp rsp_of(logic [1:0] status, logic [15:0] nid, logic [15:0] par,
                                    logic [7:0] prio, logic [31:0] ticks, logic [3:0] slot,
                                    logic [15:0] id);
        t_rsp o;
        o.status     = status;
        o.new_id     = nid;
        o.parent_out = par;
        o.prio_out   = prio;
        o.ticks_out  = ticks;
        o.cur_slot   = slot;
        o.cur_id     = id;
        return o;
    endfunction

    function automatic void add_row(logic [2:0] op, logic [15:0] tid, logic [7:0] prio,
                                    bit typed = 1'b0, t_rsp want = '0);
        t_dir_row row;
        row.cmd.op        = op;
        row.cmd.target_id = tid;
        row.cmd.prio_in   = prio;
        row.typed         = typed;
        row.want          = want;
        dir_rows.push_back(row);
    endfunction

    // mostly ids of live tasks, sometimes misses anywhere in the 16-bit range
    function automatic logic [15:0] pick_target();
        int start;
        if (live_count > 0 && $urandom_range(0, 7) != 0) begin
            start = $urandom_range(0, N_SLOTS - 1);
            for (int i = 0; i < N_SLOTS; i++)
                if (tbl_live[(start + i) % N_SLOTS])
                    return tbl_id[(start + i) % N_SLOTS];
        end
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom_range(0, next_id + 2));
        return 16'($urandom);
    endfunction

    function automatic t_req random_cmd(t_mode mode);
        int         weights[4][6] = '{'{40, 5, 35, 10, 5, 5},
                                      '{5, 55, 5, 20, 10, 5},
                                      '{20, 20, 15, 25, 15, 5},
                                      '{10, 10, 5, 55, 15, 5}};
        logic [2:0] op_of[5] = '{OP_CREATE, OP_EXIT, OP_FORK, OP_TICK, OP_QUERY};
        int         roll, acc, pick;
        t_req       r;
        roll = $urandom_range(0, 99);
        acc  = 0;
        pick = 5;
        for (int k = 0; k < 6; k++) begin
            acc += weights[mode][k];
            if (roll < acc) begin
                pick = k;
                break;
            end
        end
        r.op        = (pick < 5) ? op_of[pick] : 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        r.target_id = pick_target();
        r.prio_in   = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic issue(input t_req r, input bit typed, input t_rsp want);
        int   gap;
        t_rsp pred;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.op        <= r.op;
        req_ch.target_id <= r.target_id;
        req_ch.prio_in   <= r.prio_in;
        do @(posedge i_clk); while (!req_ch.ready);
        pred = apply_command(r);
        pending_rsp.push_back(typed ? want : pred);
        op_seen[r.op]++;
        if (pred.status == ST_FULL)
            n_full++;
        if (pred.status == ST_NOT_FOUND)
            n_not_found++;
        if (live_count == 0)
            n_empty_table++;
        if (live_count > peak_live)
            peak_live = live_count;
    endtask

    task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_rsp(t_rsp got);
        t_rsp want;
        if (pending_rsp.size() == 0) begin
            $display("%0t: response with no request outstanding: %p", $time, got);
            errors++;
        end else begin
            want = pending_rsp.pop_front();
            cmp_field("status", want.status, got.status);
            cmp_field("new_id", want.new_id, got.new_id);
            cmp_field("parent_out", want.parent_out, got.parent_out);
            cmp_field("prio_out", want.prio_out, got.prio_out);
            cmp_field("ticks_out", want.ticks_out, got.ticks_out);
            cmp_field("cur_slot", want.cur_slot, got.cur_slot);
            cmp_field("cur_id", want.cur_id, got.cur_id);
        end
    endtask

    // response side: random backpressure per response
    initial begin
        int   gap;
        t_rsp got;
        rsp_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = idle_on ? $urandom_range(0, 4) : 0;
            if (gap != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            got.status     = rsp_ch.status;
            got.new_id     = rsp_ch.new_id;
            got.parent_out = rsp_ch.parent_out;
            got.prio_out   = rsp_ch.prio_out;
            got.ticks_out  = rsp_ch.ticks_out;
            got.cur_slot   = rsp_ch.cur_slot;
            got.cur_id     = rsp_ch.cur_id;
            check_rsp(got);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time, stall_cycles);
            $display("process_table_round_robin regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_req  r;
        t_mode mode;
        int    len, real_items;
        errors           = 0;
        stall_cycles     = 0;
        n_full           = 0;
        n_not_found      = 0;
        n_empty_table    = 0;
        peak_live        = 1;
        real_items       = 0;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.op        = OP_CREATE;
        req_ch.target_id = '0;
        req_ch.prio_in   = '0;
        table_reset();

        add_row(OP_QUERY, IDLE_ID, 8'hFF, 1'b1,
                rsp_of(ST_OK, 16'd0, 16'd0, IDLE_PRIO, 32'd0, 4'd0, IDLE_ID));
        add_row(OP_CREATE, 16'd0, 8'd0, 1'b1,
                rsp_of(ST_OK, FIRST_ID, 16'd0, 8'd0, 32'd0, 4'd0, IDLE_ID));
        add_row(OP_CREATE, 16'hFFFF, 8'hFF, 1'b1,
                rsp_of(ST_OK, 16'd3, 16'd0, 8'd0, 32'd0, 4'd0, IDLE_ID));
        add_row(OP_QUERY, 16'd3, 8'd0, 1'b1,
                rsp_of(ST_OK, 16'd0, IDLE_ID, 8'hFF, 32'd0, 4'd0, IDLE_ID));
        add_row(OP_QUERY, FIRST_ID, 8'd0, 1'b1,
                rsp_of(ST_OK, 16'd0, IDLE_ID, DEFAULT_PRIO, 32'd0, 4'd0, IDLE_ID));
        add_row(OP_FORK, 16'd3, 8'd0);
        add_row(OP_QUERY, 16'd4, 8'd0);
        add_row(OP_EXIT, 16'hFFFF, 8'd0, 1'b1,
                rsp_of(ST_NOT_FOUND, 16'd0, 16'd0, 8'd0, 32'd0, 4'd0, IDLE_ID));
        add_row(OP_QUERY, 16'd0, 8'd0, 1'b1,
                rsp_of(ST_NOT_FOUND, 16'd0, 16'd0, 8'd0, 32'd0, 4'd0, IDLE_ID));
        add_row(OP_FORK, 16'hFFFF, 8'hAA, 1'b1,
                rsp_of(ST_NOT_FOUND, 16'd0, 16'd0, 8'd0, 32'd0, 4'd0, IDLE_ID));
        add_row(OP_TICK, 16'd0, 8'd0);
        add_row(OP_TICK, 16'hFFFF, 8'hFF);
        add_row(OP_QUERY, IDLE_ID, 8'd0);
        // kill the running task, then tick from a dead slot
        add_row(OP_EXIT, 16'd3, 8'd0);
        add_row(OP_TICK, 16'd0, 8'd0);
        add_row(OP_CREATE, 16'd0, 8'd1);
        add_row(OP_QUERY, 16'd5, 8'd0);
        add_row(OP_UNDEF_LO, 16'hFFFF, 8'hFF);
        add_row(3'd6, 16'h5555, 8'h55);
        add_row(OP_UNDEF_HI, 16'd0, 8'd0);
        add_row(OP_TICK, 16'd0, 8'd0);
        add_row(OP_EXIT, IDLE_ID, 8'd0);
        add_row(OP_QUERY, IDLE_ID, 8'd0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            issue(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

        // episodes: fill the table, drain it, mixed traffic, mostly ticks
        while (real_items < RANDOM_ITEMS) begin
            mode    = t_mode'($urandom_range(0, 3));
            idle_on = ($urandom_range(0, 3) != 0);
            len     = $urandom_range(8, 40);
            repeat (len) begin
                r = random_cmd(mode);
                issue(r, 1'b0, '0);
                if (r.op <= OP_QUERY)
                    real_items++;
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_rsp.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, pending_rsp.size());
            errors++;
        end

        $display("ops: create %0d exit %0d fork %0d tick %0d query %0d undefined %0d",
                 op_seen[OP_CREATE], op_seen[OP_EXIT], op_seen[OP_FORK],
                 op_seen[OP_TICK], op_seen[OP_QUERY],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        $display("table full %0d, not found %0d, empty table %0d, peak live %0d, errors %0d",
                 n_full, n_not_found, n_empty_table, peak_live, errors);
        if (errors == 0) begin
            $display("process_table_round_robin regression: pass");
        end else begin
            $display("process_table_round_robin regression: fail");
        end
        $finish;
    end

endmodule
